### design/multichannel_pid_step_defines.svh
// Assertion helpers shared by the design files.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MULTICHANNEL_PID_STEP_DEFINES_SVH
`define MULTICHANNEL_PID_STEP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define MPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define MPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mpid_pkg.sv
package mpid_pkg;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int CHN_W     = 4;
  localparam int IDX_W     = 3;

  // Bank size and fixed-point format
  localparam int CHANNELS  = 16;
  localparam int FRAC_BITS = 16;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Queue between front and back; depth is a power of two
  localparam int QDEPTH    = 4;
  localparam int QP_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W     = $clog2(QDEPTH + 1);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_STEP  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [IDX_W-1:0] {
    COEF_KP      = 3'd0,
    COEF_KI      = 3'd1,
    COEF_KD      = 3'd2,
    COEF_DEAD    = 3'd3,
    COEF_INT_LIM = 3'd4,
    COEF_OUT_LIM = 3'd5
  } coef_e;

  // One classified beat: writes carry the value in data_a
  typedef struct packed {
    logic                     is_write;
    logic [CHN_W-1:0]         channel;
    coef_e                    coef;
    logic signed [DATA_W-1:0] data_a;
    logic signed [DATA_W-1:0] data_b;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W+1:DATA_W-1] == 3'b000 || v[DATA_W+1:DATA_W-1] == 3'b111) begin
      r = v[DATA_W-1:0];
    end else begin
      r = v[DATA_W+1] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

  // Arithmetic shift of a full product by the fraction width, then saturate
  function automatic logic signed [DATA_W-1:0] scale_prod(
    input logic signed [2*DATA_W-1:0] p
  );
    logic signed [2*DATA_W-1:0] s;
    logic signed [DATA_W-1:0]   r;
    s = p >>> FRAC_BITS;
    if ((&s[2*DATA_W-1:DATA_W-1]) || !(|s[2*DATA_W-1:DATA_W-1])) begin
      r = s[DATA_W-1:0];
    end else begin
      r = s[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

  // Symmetric clamp: upper bound first, then the negated bound
  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [DATA_W-1:0] v,
    input logic signed [DATA_W-1:0] lim
  );
    logic signed [DATA_W:0]   nlim;
    logic signed [DATA_W-1:0] t;
    nlim = -$signed({lim[DATA_W-1], lim});
    t    = (v > lim) ? lim : v;
    if ($signed({t[DATA_W-1], t}) < nlim) begin
      t = (nlim[DATA_W] != nlim[DATA_W-1]) ? SAT_MAX : nlim[DATA_W-1:0];
    end
    return t;
  endfunction

endpackage

### design/mpid_in_if.sv
interface mpid_in_if import mpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [CHN_W-1:0]         channel;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measure;
  logic [IDX_W-1:0]         coef_index;
  logic signed [DATA_W-1:0] coef_value;

  modport source (
    output valid, operation, channel, target, measure, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, target, measure, coef_index, coef_value,
    output ready
  );
endinterface

### design/mpid_out_if.sv
interface mpid_out_if import mpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic [CHN_W-1:0]         out_channel;

  modport source (
    output valid, drive, out_channel,
    input  ready
  );
  modport sink (
    input  valid, drive, out_channel,
    output ready
  );
endinterface

### design/mpid_front.sv
`include "multichannel_pid_step_defines.svh"

module mpid_front import mpid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpid_in_if.sink    in_i,
  input  logic       pop_i,
  output q_head_t    head_o
);

  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  q_entry_t         mem_q [QDEPTH];
  q_entry_t         entry_d;
  logic             ch_ok;
  logic             keep;
  logic             push;

  // Classify the incoming beat: drop anything that has no effect
  always_comb begin
    ch_ok = 32'(in_i.channel) < 32'(CHANNELS);
    if (in_i.operation == OP_WRITE) begin
      keep = ch_ok && (in_i.coef_index <= COEF_OUT_LIM);
    end else begin
      keep = ch_ok;
    end
    entry_d.is_write = (in_i.operation == OP_WRITE);
    entry_d.channel  = in_i.channel;
    entry_d.coef     = coef_e'(in_i.coef_index);
    entry_d.data_a   = (in_i.operation == OP_WRITE) ? in_i.coef_value : in_i.target;
    entry_d.data_b   = in_i.measure;
  end

  assign in_i.ready = (count_q != CNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready && keep;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued beats
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  `MPID_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != '0, "pop from an empty queue")
  `MPID_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QDEPTH), "queue overfilled")

endmodule

### design/mpid_back.sv
`include "multichannel_pid_step_defines.svh"

module mpid_back import mpid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_head_t    head_i,
  output logic       pop_o,
  mpid_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INTEG = 5'b00010,
    S_MULT  = 5'b00100,
    S_SUM   = 5'b01000,
    S_OUT   = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  // Per-channel stores
  logic signed [DATA_W-1:0] kp_q   [CHANNELS];
  logic signed [DATA_W-1:0] ki_q   [CHANNELS];
  logic signed [DATA_W-1:0] kd_q   [CHANNELS];
  logic signed [DATA_W-1:0] db_q   [CHANNELS];
  logic signed [DATA_W-1:0] ilim_q [CHANNELS];
  logic signed [DATA_W-1:0] olim_q [CHANNELS];
  logic signed [DATA_W-1:0] isum_st_q [CHANNELS];
  logic signed [DATA_W-1:0] lerr_st_q [CHANNELS];

  // Step working registers
  logic [CHN_W-1:0]           ch_q;
  logic [CH_W-1:0]            idx_q;
  logic [CH_W-1:0]            head_idx;
  logic signed [DATA_W-1:0]   err_q, err_d;
  logic signed [DATA_W-1:0]   isum_q, isum_d;
  logic signed [DATA_W-1:0]   dif_q, dif_d;
  logic signed [2*DATA_W-1:0] p_prod_q, i_prod_q, d_prod_q;
  logic signed [DATA_W-1:0]   raw_q, raw_d;
  logic signed [DATA_W-1:0]   ilim_cur;

  // Output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q;
  logic [CHN_W-1:0]         och_q;
  logic                     out_free;

  logic signed [DATA_W-1:0] raw_err;
  logic signed [DATA_W:0]   err_w, db_w;

  assign head_idx = CH_W'(head_i.entry.channel);
  assign ilim_cur = ilim_q[idx_q];
  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && head_i.valid;

  // Error with dead band, taken straight from the queue head
  always_comb begin
    raw_err = sat34(34'(head_i.entry.data_a) - 34'(head_i.entry.data_b));
    err_w   = 33'(raw_err);
    db_w    = 33'(db_q[head_idx]);
    err_d   = ((err_w < db_w) && (err_w > -db_w)) ? '0 : raw_err;
  end

  // Integral update and error difference
  always_comb begin
    isum_d = clamp_sym(sat34(34'(isum_st_q[idx_q]) + 34'(err_q)), ilim_cur);
    dif_d  = sat34(34'(err_q) - 34'(lerr_st_q[idx_q]));
  end

  // Sum of scaled terms
  assign raw_d = sat34(34'(scale_prod(p_prod_q)) + 34'(scale_prod(i_prod_q))
                     + 34'(scale_prod(d_prod_q)));

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid && !head_i.entry.is_write) begin
          state_d = S_INTEG;
        end
      end
      S_INTEG: state_d = S_MULT;
      S_MULT:  state_d = S_SUM;
      S_SUM:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Apply coefficient writes and per-step state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        kp_q[i]      <= '0;
        ki_q[i]      <= '0;
        kd_q[i]      <= '0;
        db_q[i]      <= '0;
        ilim_q[i]    <= '0;
        olim_q[i]    <= '0;
        isum_st_q[i] <= '0;
        lerr_st_q[i] <= '0;
      end
    end else begin
      if (pop_o && head_i.entry.is_write) begin
        unique case (head_i.entry.coef)
          COEF_KP:      kp_q[head_idx]   <= head_i.entry.data_a;
          COEF_KI:      ki_q[head_idx]   <= head_i.entry.data_a;
          COEF_KD:      kd_q[head_idx]   <= head_i.entry.data_a;
          COEF_DEAD:    db_q[head_idx]   <= head_i.entry.data_a;
          COEF_INT_LIM: ilim_q[head_idx] <= head_i.entry.data_a;
          COEF_OUT_LIM: olim_q[head_idx] <= head_i.entry.data_a;
          default: ;
        endcase
      end
      if (state_q == S_INTEG) begin
        isum_st_q[idx_q] <= isum_d;
        lerr_st_q[idx_q] <= err_q;
      end
    end
  end

  // Step datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o && !head_i.entry.is_write) begin
      ch_q  <= head_i.entry.channel;
      idx_q <= head_idx;
      err_q <= err_d;
    end
    if (state_q == S_INTEG) begin
      isum_q <= isum_d;
      dif_q  <= dif_d;
    end
    if (state_q == S_MULT) begin
      p_prod_q <= 64'(kp_q[idx_q]) * 64'(err_q);
      i_prod_q <= 64'(ki_q[idx_q]) * 64'(isum_q);
      d_prod_q <= 64'(kd_q[idx_q]) * 64'(dif_q);
    end
    if (state_q == S_SUM) begin
      raw_q <= raw_d;
    end
  end

  // Output beat register: load on the last step, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      drive_q <= clamp_sym(raw_q, olim_q[idx_q]);
      och_q   <= ch_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive       = drive_q;
  assign out_o.out_channel = och_q;

  `MPID_ASSERT_IMP(a_integ_in_limit, (state_q == S_MULT) && !ilim_cur[DATA_W-1], (isum_q <= ilim_cur) && (isum_q >= -ilim_cur), "integral outside its limit")
  `MPID_ASSERT_IMP(a_out_from_seq, $rose(out_valid_q), $past(state_q) == S_OUT, "result beat without a finished step")

endmodule

### design/multichannel_pid_step.sv
// Channel  Dir  Modport  Payload
// in_i     in   sink     operation, channel, target, measure, coef_index, coef_value
// out_o    out  source   drive, out_channel
//
// Input beats are taken every cycle while the 4-entry queue has room.
// A control step walks the back sequencer through its steps (error, integral,
// multiply, sum, clamp); a write is applied on its pop; dropped beats never queue.
// Reset clears all coefficients, integrals and last errors at once.
// A result waits in the output register while out_o is stalled; the
// sequencer then holds in its final step and the queue keeps filling.
module multichannel_pid_step import mpid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpid_in_if.sink    in_i,
  mpid_out_if.source out_o
);

  q_head_t head;
  logic    pop;

  mpid_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  mpid_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### bench/tb_multichannel_pid_step.sv
`timescale 1ns / 100ps

module tb_multichannel_pid_step;
  import mpid_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct {
    word_t            drive;
    logic [CHN_W-1:0] channel;
  } drive_item_t;

  // Indexes that no coefficient uses; writes to them are dropped
  localparam logic [IDX_W-1:0] COEF_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] COEF_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS    = 1450;
  localparam int TAIL_ITEMS      = 150;
  localparam int HOLD_AFTER      = 600;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 30;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int REPORT_CAP      = 200;

  // Tracks every channel's coefficients and loop state, and the drives still owed
  class pid_bank_tracker;
    word_t       kp[CHANNELS];
    word_t       ki[CHANNELS];
    word_t       kd[CHANNELS];
    word_t       dead[CHANNELS];
    word_t       int_lim[CHANNELS];
    word_t       out_lim[CHANNELS];
    word_t       integ[CHANNELS];
    word_t       last_err[CHANNELS];
    drive_item_t drive_due[$];
    int          errors;

    function new();
      foreach (kp[c]) begin
        kp[c]       = '0;
        ki[c]       = '0;
        kd[c]       = '0;
        dead[c]     = '0;
        int_lim[c]  = '0;
        out_lim[c]  = '0;
        integ[c]    = '0;
        last_err[c] = '0;
      end
      errors = 0;
    endfunction

    static function word_t sat_word(longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return word_t'(v);
    endfunction

    // Exact product, floor division by the fraction scale, then saturate
    static function word_t mul_q(word_t a, word_t b);
      return sat_word((longint'(a) * longint'(b)) >>> FRAC_BITS);
    endfunction

    // Upper bound first, then the negated bound
    static function word_t clamp_to(word_t v, word_t lim);
      word_t r;
      r = v;
      if (r > lim) r = lim;
      if (longint'(r) < -longint'(lim)) r = sat_word(-longint'(lim));
      return r;
    endfunction

    function void predict_step(logic [CHN_W-1:0] ch, word_t tgt, word_t meas);
      word_t       err;
      word_t       p;
      word_t       i;
      word_t       d;
      drive_item_t res;
      err = sat_word(longint'(tgt) - longint'(meas));
      // zero the error strictly inside the dead band
      if (longint'(err) < longint'(dead[ch]) && longint'(err) > -longint'(dead[ch]))
        err = '0;
      integ[ch] = clamp_to(sat_word(longint'(integ[ch]) + longint'(err)), int_lim[ch]);
      p = mul_q(kp[ch], err);
      i = mul_q(ki[ch], integ[ch]);
      d = mul_q(kd[ch], sat_word(longint'(err) - longint'(last_err[ch])));
      res.drive   = clamp_to(sat_word(longint'(p) + longint'(i) + longint'(d)), out_lim[ch]);
      res.channel = ch;
      last_err[ch] = err;
      drive_due.push_back(res);
    endfunction

    function void note_beat(op_e op, logic [CHN_W-1:0] ch, word_t tgt, word_t meas,
                            logic [IDX_W-1:0] idx, word_t val);
      if (int'(ch) >= CHANNELS) return;
      if (op == OP_STEP) begin
        predict_step(ch, tgt, meas);
        return;
      end
      case (idx)
        COEF_KP:      kp[ch]      = val;
        COEF_KI:      ki[ch]      = val;
        COEF_KD:      kd[ch]      = val;
        COEF_DEAD:    dead[ch]    = val;
        COEF_INT_LIM: int_lim[ch] = val;
        COEF_OUT_LIM: out_lim[ch] = val;
        default: ;
      endcase
    endfunction

    function void check_drive(word_t drive, logic [CHN_W-1:0] ch);
      drive_item_t exp_item;
      if (drive_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected drive: expected none, actual ch %0d drive %h",
                   $time, ch, drive);
        return;
      end
      exp_item = drive_due.pop_front();
      if (ch !== exp_item.channel) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                   $time, exp_item.channel, ch);
      end
      if (drive !== exp_item.drive) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: drive mismatch on ch %0d: expected %h, actual %h",
                   $time, exp_item.channel, exp_item.drive, drive);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mpid_in_if  in_if ();
  mpid_out_if out_if ();

  pid_bank_tracker pid_bank = new();

  bit tail_phase  = 1'b0;
  bit hold_done   = 1'b0;
  int beats_taken = 0;
  int idle_cycles = 0;

  multichannel_pid_step i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      pid_bank.note_beat(op_e'(in_if.operation), in_if.channel, in_if.target,
                         in_if.measure, in_if.coef_index, in_if.coef_value);
      beats_taken++;
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      pid_bank.check_drive(out_if.drive, out_if.out_channel);
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin
    int burst;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      burst = 1;
      if (!hold_done && beats_taken >= HOLD_AFTER) begin
        out_if.ready <= 1'b0;
        hold_done = 1'b1;
        burst = HOLD_CYCLES;
      end else if (tail_phase) begin
        out_if.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        burst = $urandom_range(1, 17);
      end else begin
        out_if.ready <= 1'b1;
        burst = $urandom_range(1, 60);
      end
      repeat (burst - 1) @(posedge clk_i);
    end
  end

  // Offer one beat, with an occasional gap ahead of it; return once it is taken
  task automatic send_beat(op_e op, logic [CHN_W-1:0] ch, word_t tgt, word_t meas,
                           logic [IDX_W-1:0] idx, word_t val);
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.channel    <= ch;
    in_if.target     <= tgt;
    in_if.measure    <= meas;
    in_if.coef_index <= idx;
    in_if.coef_value <= val;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic write_coef(logic [CHN_W-1:0] ch, logic [IDX_W-1:0] idx, word_t val);
    send_beat(OP_WRITE, ch, word_t'($urandom()), word_t'($urandom()), idx, val);
  endtask

  task automatic run_step(logic [CHN_W-1:0] ch, word_t tgt, word_t meas);
    send_beat(OP_STEP, ch, tgt, meas, IDX_W'($urandom_range(0, 7)),
              word_t'($urandom()));
  endtask

  // Setpoints and measurements: mostly within a few units, sometimes anywhere
  function automatic word_t pick_signal();
    case ($urandom_range(0, 9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3:    return word_t'($urandom());
      default: return word_t'($urandom_range(0, 'hA0000)) - word_t'('h50000);
    endcase
  endfunction

  function automatic word_t pick_coef(logic [IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return SAT_MIN;
    if (roll == 1) return SAT_MAX;
    if (roll == 2) return word_t'($urandom());
    if (roll == 3) return '0;
    case (idx)
      COEF_DEAD: begin
        if (roll == 4) return -word_t'($urandom_range(1, 'h20000));
        return word_t'($urandom_range(0, 'h20000));
      end
      COEF_INT_LIM, COEF_OUT_LIM: begin
        if (roll == 4) return -word_t'($urandom_range(1, 'h80000));
        return word_t'($urandom_range(1, 'h200000));
      end
      default: return word_t'($urandom_range(0, 'h80000)) - word_t'('h40000);
    endcase
  endfunction

  initial begin
    int               n;
    logic [CHN_W-1:0] ch;
    logic [IDX_W-1:0] idx;
    word_t            tgt;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_STEP;
    in_if.channel    <= '0;
    in_if.target     <= '0;
    in_if.measure    <= '0;
    in_if.coef_index <= '0;
    in_if.coef_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // untouched channel: every coefficient still zero
    run_step(4'd1, SAT_MAX, SAT_MIN);

    // moderate gains, wide limits
    write_coef(4'd0, COEF_KP, 32'sh0001_0000);
    write_coef(4'd0, COEF_KI, 32'sh0000_8000);
    write_coef(4'd0, COEF_KD, 32'sh0000_4000);
    write_coef(4'd0, COEF_DEAD, 32'sh0000_0100);
    write_coef(4'd0, COEF_INT_LIM, SAT_MAX);
    write_coef(4'd0, COEF_OUT_LIM, SAT_MAX);

    // spare indexes must leave the channel alone
    write_coef(4'd0, COEF_SPARE_LO, SAT_MIN);
    write_coef(4'd0, COEF_SPARE_HI, SAT_MIN);

    // error just inside, then exactly on, the dead band
    run_step(4'd0, 32'sh0000_0080, '0);
    run_step(4'd0, '0, 32'sh0000_0100);

    // error saturates both ways
    run_step(4'd0, SAT_MAX, SAT_MIN);
    run_step(4'd0, SAT_MIN, SAT_MAX);

    // negative integral limit
    write_coef(4'd0, COEF_INT_LIM, -32'sd5);
    run_step(4'd0, 32'sh0003_0000, '0);

    // most negative output limit negates to the top value
    write_coef(4'd0, COEF_OUT_LIM, SAT_MIN);
    run_step(4'd0, 32'sh0001_0000, '0);

    // negative dead band never zeroes the error
    write_coef(4'd0, COEF_DEAD, -32'sh0000_0100);
    run_step(4'd0, 32'sd1, '0);

    // extreme gains saturate the products
    write_coef(4'd0, COEF_KP, SAT_MAX);
    write_coef(4'd0, COEF_KD, SAT_MIN);
    run_step(4'd0, SAT_MAX, '0);

    // top channel
    write_coef(4'd15, COEF_KP, SAT_MIN);
    run_step(4'd15, SAT_MIN, SAT_MAX);

    // tune every channel so that the loops do real work
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k <= int'(COEF_OUT_LIM); k++) begin
        idx = IDX_W'(k);
        write_coef(CHN_W'(c), idx, pick_coef(idx));
      end
    end

    // mostly steps, with retuning and a few dropped writes in between
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
      ch = CHN_W'($urandom_range(0, CHANNELS - 1));
      case ($urandom_range(0, 19))
        0: begin
          write_coef(ch, $urandom_range(0, 1) ? COEF_SPARE_HI : COEF_SPARE_LO,
                     word_t'($urandom()));
        end
        1, 2, 3, 4, 5: begin
          idx = IDX_W'($urandom_range(0, int'(COEF_OUT_LIM)));
          write_coef(ch, idx, pick_coef(idx));
          n++;
        end
        6, 7, 8: begin
          run_step(ch, pick_signal(), pick_signal());
          n++;
        end
        default: begin
          // measurement close to its setpoint
          tgt = pick_signal();
          run_step(ch, tgt, tgt - word_t'($urandom_range(0, 'h40000)) + word_t'('h20000));
          n++;
        end
      endcase
    end
    in_if.valid <= 1'b0;

    // wait for every owed drive, then let the pipeline settle
    @(posedge clk_i);
    while (pid_bank.drive_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pid_bank.errors == 0 && pid_bank.drive_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
